// ----- rtl/core/dlex_pkg.sv -----
// ----------------------------------------------------------------------------
// dlex_pkg
// Shared types, character codes, token codes and keyword helpers for the
// document byte lexer.
// ----------------------------------------------------------------------------
package dlex_pkg;

    localparam int MaxResults = 4;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_input;
    } dlex_in_t;

    typedef struct packed {
        logic       event_kind;
        logic [3:0] token_type;
        logic [7:0] data_byte;
        logic       last_of_run;
    } dlex_out_t;

    typedef enum logic [5:0] {
        MODE_IDLE    = 6'b000001,
        MODE_WORD    = 6'b000010,
        MODE_NUMBER  = 6'b000100,
        MODE_STRING  = 6'b001000,
        MODE_ESCAPE  = 6'b010000,
        MODE_COMMENT = 6'b100000
    } dlex_mode_t;

    typedef struct packed {
        dlex_mode_t mode;
        logic [2:0] word_length;
        logic [2:0] kw_cand;      // bit 0 null, bit 1 true, bit 2 false
    } dlex_state_t;

    typedef struct packed {
        dlex_out_t [MaxResults-1:0] res;
        logic [2:0]                 count;
    } dlex_burst_t;

    localparam logic       EV_DATA = 1'b0;
    localparam logic       EV_DONE = 1'b1;

    localparam logic [3:0] TT_KEY    = 4'd0;
    localparam logic [3:0] TT_NUMBER = 4'd1;
    localparam logic [3:0] TT_STRING = 4'd2;
    localparam logic [3:0] TT_NULL   = 4'd3;
    localparam logic [3:0] TT_TRUE   = 4'd4;
    localparam logic [3:0] TT_FALSE  = 4'd5;
    localparam logic [3:0] TT_COLON  = 4'd6;
    localparam logic [3:0] TT_LBRACK = 4'd7;
    localparam logic [3:0] TT_RBRACK = 4'd8;
    localparam logic [3:0] TT_LBRACE = 4'd9;
    localparam logic [3:0] TT_RBRACE = 4'd10;
    localparam logic [3:0] TT_LPAREN = 4'd11;
    localparam logic [3:0] TT_RPAREN = 4'd12;
    localparam logic [3:0] TT_PLUS   = 4'd13;
    localparam logic [3:0] TT_MINUS  = 4'd14;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_UPPERE = 8'h45;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LOWERE = 8'h65;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // Keyword spellings, one character per position
    function automatic logic [7:0] null_char(logic [1:0] idx);
        logic [7:0] r;
        unique case (idx)
            2'd0:    r = 8'h6E;
            2'd1:    r = 8'h75;
            default: r = 8'h6C;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] true_char(logic [1:0] idx);
        logic [7:0] r;
        unique case (idx)
            2'd0: r = 8'h74;
            2'd1: r = 8'h72;
            2'd2: r = 8'h75;
            2'd3: r = 8'h65;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] false_char(logic [2:0] idx);
        logic [7:0] r;
        unique case (idx)
            3'd0:    r = 8'h66;
            3'd1:    r = 8'h61;
            3'd2:    r = 8'h6C;
            3'd3:    r = 8'h73;
            3'd4:    r = 8'h65;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] kw_update(logic [2:0] len, logic [2:0] cand,
                                             logic [7:0] c);
        logic [2:0] r;
        r = cand;
        if (!(len < 3'd4 && c == null_char(len[1:0])))
            r[0] = 1'b0;
        if (!(len < 3'd4 && c == true_char(len[1:0])))
            r[1] = 1'b0;
        if (!(len < 3'd5 && c == false_char(len)))
            r[2] = 1'b0;
        return r;
    endfunction

    function automatic logic [3:0] word_type(logic [2:0] len, logic [2:0] cand);
        logic [3:0] r;
        priority if (cand[0] && len == 3'd4)
            r = TT_NULL;
        else if (cand[1] && len == 3'd4)
            r = TT_TRUE;
        else if (cand[2] && len == 3'd5)
            r = TT_FALSE;
        else
            r = TT_KEY;
        return r;
    endfunction

    function automatic dlex_out_t mk_res(logic kind, logic [3:0] ttype, logic [7:0] data);
        dlex_out_t r;
        r.event_kind  = kind;
        r.token_type  = ttype;
        r.data_byte   = data;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage

// ----- rtl/core/document_byte_lexer_core.sv -----
// ----------------------------------------------------------------------------
// document_byte_lexer_core
// Streaming lexer for a JSON-like text format, one byte in, token events out.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one input byte per word, with end_of_input
//   set on the final byte of a document. m_valid/m_ready/m_data carry token
//   events: data characters of an open word, number or string, and token
//   completions. last_of_run marks the final event caused by one input byte.
//   An accepted byte is held in the input register, then its events are
//   loaded into the result buffer, whose head word drives m_data.
//   Throughput: one byte per cycle while each byte causes at most one event
//   and m_ready stays high. A byte that causes several events (at most
//   three) holds the input until the single-word result port has drained
//   the result buffer. Bytes that cause no event pass at one per cycle
//   once the result buffer is empty.
//   Reset clears the input register, the result buffer and the scan state
//   (idle, no open token). When m_ready is low the result buffer holds and
//   the input register keeps taking one more byte before s_ready drops.
// ----------------------------------------------------------------------------
module document_byte_lexer_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dlex_pkg::dlex_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output dlex_pkg::dlex_out_t m_data
);
    import dlex_pkg::*;

    logic        in_valid_reg, in_valid_next;
    dlex_in_t    in_data_reg,  in_data_next;
    dlex_state_t state_reg,    state_next;
    dlex_out_t [MaxResults-1:0] res_reg, res_next;
    logic [2:0]  cnt_reg,      cnt_next;

    dlex_state_t step_state;
    dlex_burst_t burst;
    logic        pop;
    logic        advance;

    dlex_step u_step (
        .cur_state  (state_reg),
        .in_word    (in_data_reg),
        .next_state (step_state),
        .burst      (burst)
    );

    assign m_valid = (cnt_reg != 3'd0);
    assign m_data  = res_reg[0];
    assign pop     = m_valid && m_ready;
    // buffer is free once its last word leaves this cycle
    assign advance = in_valid_reg && (cnt_reg == 3'd0 || (cnt_reg == 3'd1 && m_ready));
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_data_next  = in_data_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
            in_data_next  = s_data;
        end
    end

    always_comb begin
        state_next = state_reg;
        res_next   = res_reg;
        cnt_next   = cnt_reg;
        if (advance) begin
            state_next = step_state;
            res_next   = burst.res;
            cnt_next   = burst.count;
        end else if (pop) begin
            for (int i = 0; i < MaxResults - 1; i++)
                res_next[i] = res_reg[i+1];
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            cnt_reg           <= 3'd0;
            state_reg.mode    <= MODE_IDLE;
            state_reg.word_length <= 3'd0;
            state_reg.kw_cand <= 3'b111;
        end else begin
            in_valid_reg <= in_valid_next;
            cnt_reg      <= cnt_next;
            state_reg    <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_data_reg <= in_data_next;
        res_reg     <= res_next;
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 3'(MaxResults))
        else $error("result buffer count out of range");

    a_last_is_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.last_of_run) |-> (cnt_reg == 3'd1))
        else $error("last_of_run word is not the buffer tail");

    a_run_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !m_data.last_of_run) |=> m_valid)
        else $error("gap inside a run of result words");

    a_eoi_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_data_reg.end_of_input) |=>
            (state_reg.mode == MODE_IDLE && state_reg.word_length == 3'd0 &&
             state_reg.kw_cand == 3'b111))
        else $error("scan state not cleared after end of input");

endmodule

// ----- rtl/core/dlex_step.sv -----
// ----------------------------------------------------------------------------
// dlex_step
// Per-byte lexer step: from the current scan state and one input word,
// produces the next state and the burst of up to three result words.
// ----------------------------------------------------------------------------
module dlex_step (
    input  dlex_pkg::dlex_state_t cur_state,
    input  dlex_pkg::dlex_in_t    in_word,
    output dlex_pkg::dlex_state_t next_state,
    output dlex_pkg::dlex_burst_t burst
);
    import dlex_pkg::*;

    logic [7:0]  c;
    logic [2:0]  n;
    logic [2:0]  n_last;
    logic        do_idle;
    logic        sym_hit;
    logic [3:0]  sym_type;
    dlex_state_t st;
    dlex_out_t [MaxResults-1:0] res;

    assign c = in_word.byte_value;

    always_comb begin
        st       = cur_state;
        res      = '0;
        n        = 3'd0;
        n_last   = 3'd0;
        do_idle  = 1'b0;
        sym_hit  = 1'b0;
        sym_type = TT_KEY;

        unique case (cur_state.mode)
            MODE_WORD: begin
                if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
                    st.kw_cand = kw_update(cur_state.word_length, cur_state.kw_cand, c);
                    if (cur_state.word_length != 3'd7)
                        st.word_length = cur_state.word_length + 3'd1;
                    res[n[1:0]] = mk_res(EV_DATA, TT_KEY, c);
                    n = n + 3'd1;
                end else begin
                    res[n[1:0]] = mk_res(EV_DONE,
                        word_type(cur_state.word_length, cur_state.kw_cand), 8'h00);
                    n = n + 3'd1;
                    do_idle = 1'b1;
                end
            end
            MODE_NUMBER: begin
                if (is_digit(c) || c == CH_UNDER || c == CH_DOT || c == CH_PLUS ||
                    c == CH_MINUS || c == CH_LOWERE || c == CH_UPPERE) begin
                    res[n[1:0]] = mk_res(EV_DATA, TT_NUMBER, c);
                    n = n + 3'd1;
                end else begin
                    res[n[1:0]] = mk_res(EV_DONE, TT_NUMBER, 8'h00);
                    n = n + 3'd1;
                    do_idle = 1'b1;
                end
            end
            MODE_STRING: begin
                if (c == CH_QUOTE) begin
                    res[n[1:0]] = mk_res(EV_DONE, TT_STRING, 8'h00);
                    n = n + 3'd1;
                    st.mode = MODE_IDLE;
                end else if (c == CH_BSLASH) begin
                    st.mode = MODE_ESCAPE;
                end else begin
                    res[n[1:0]] = mk_res(EV_DATA, TT_STRING, c);
                    n = n + 3'd1;
                end
            end
            MODE_ESCAPE: begin
                // only \\ and \" collapse; anything else keeps the backslash
                if (c != CH_BSLASH && c != CH_QUOTE) begin
                    res[n[1:0]] = mk_res(EV_DATA, TT_STRING, CH_BSLASH);
                    n = n + 3'd1;
                end
                res[n[1:0]] = mk_res(EV_DATA, TT_STRING, c);
                n = n + 3'd1;
                st.mode = MODE_STRING;
            end
            MODE_COMMENT: begin
                if (c == CH_NL)
                    st.mode = MODE_IDLE;
            end
            default: begin
                do_idle = 1'b1;
            end
        endcase

        // byte seen from idle, also the byte that closed a word or number
        if (do_idle) begin
            st.mode = MODE_IDLE;
            if (is_alpha(c)) begin
                st.mode        = MODE_WORD;
                st.kw_cand     = kw_update(3'd0, 3'b111, c);
                st.word_length = 3'd1;
                res[n[1:0]] = mk_res(EV_DATA, TT_KEY, c);
                n = n + 3'd1;
            end else if (is_digit(c)) begin
                st.mode = MODE_NUMBER;
                res[n[1:0]] = mk_res(EV_DATA, TT_NUMBER, c);
                n = n + 3'd1;
            end else begin
                sym_hit = 1'b1;
                unique case (c)
                    CH_COLON:  sym_type = TT_COLON;
                    CH_LBRACK: sym_type = TT_LBRACK;
                    CH_RBRACK: sym_type = TT_RBRACK;
                    CH_LBRACE: sym_type = TT_LBRACE;
                    CH_RBRACE: sym_type = TT_RBRACE;
                    CH_LPAREN: sym_type = TT_LPAREN;
                    CH_RPAREN: sym_type = TT_RPAREN;
                    CH_PLUS:   sym_type = TT_PLUS;
                    CH_MINUS:  sym_type = TT_MINUS;
                    CH_QUOTE: begin
                        sym_hit = 1'b0;
                        st.mode = MODE_STRING;
                    end
                    CH_HASH: begin
                        sym_hit = 1'b0;
                        st.mode = MODE_COMMENT;
                    end
                    default: sym_hit = 1'b0;
                endcase
                if (sym_hit) begin
                    res[n[1:0]] = mk_res(EV_DONE, sym_type, 8'h00);
                    n = n + 3'd1;
                end
            end
        end

        if (in_word.end_of_input) begin
            unique case (st.mode)
                MODE_WORD: begin
                    res[n[1:0]] = mk_res(EV_DONE, word_type(st.word_length, st.kw_cand), 8'h00);
                    n = n + 3'd1;
                end
                MODE_NUMBER: begin
                    res[n[1:0]] = mk_res(EV_DONE, TT_NUMBER, 8'h00);
                    n = n + 3'd1;
                end
                MODE_ESCAPE: begin
                    res[n[1:0]] = mk_res(EV_DATA, TT_STRING, CH_BSLASH);
                    n = n + 3'd1;
                    res[n[1:0]] = mk_res(EV_DONE, TT_STRING, 8'h00);
                    n = n + 3'd1;
                end
                MODE_STRING: begin
                    res[n[1:0]] = mk_res(EV_DONE, TT_STRING, 8'h00);
                    n = n + 3'd1;
                end
                default: ;
            endcase
            st.mode        = MODE_IDLE;
            st.word_length = 3'd0;
            st.kw_cand     = 3'b111;
        end

        if (n != 3'd0) begin
            n_last = n - 3'd1;
            res[n_last[1:0]].last_of_run = 1'b1;
        end
    end

    assign next_state  = st;
    assign burst.res   = res;
    assign burst.count = n;

endmodule
